[sv/ffa_pkg.sv]
// ffa_pkg: shared types and constants for the first-fit free-list allocator.
// Holds the request/result words and the controller-to-datapath command and status structs.
// No dependencies.
package ffa_pkg;

    localparam int REQ_BYTES_W      = 16;
    localparam int ADDR_FIELD_W     = 12;
    localparam int HEAP_UNITS_W     = 12;
    localparam logic [HEAP_UNITS_W-1:0] HEAP_UNITS_RESET = 12'd4095;

    // Command codes of a request word
    typedef enum logic [1:0] {
        CMD_INIT  = 2'd0,
        CMD_ALLOC = 2'd1,
        CMD_FREE  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t                     cmd;
        logic [REQ_BYTES_W-1:0]   request_bytes;
        logic [ADDR_FIELD_W-1:0]  block_addr;
    } ffa_req_t;

    typedef struct packed {
        logic [ADDR_FIELD_W-1:0]  alloc_addr;
        logic                     status;
    } ffa_rsp_t;

    // Read address select for the link and size RAMs
    typedef enum logic [2:0] {
        RD_NONE,
        RD_ROVER,      // link @ rover
        RD_LINK,       // both @ link read data (follow the list)
        RD_BP_NX,      // size @ bp, link @ nx
        RD_NX_SIZE,    // size @ nx
        RD_P_SIZE      // size @ p
    } rd_sel_t;

    // Write select for the link and size RAMs
    typedef enum logic [2:0] {
        WR_NONE,
        WR_INIT_SENT,  // sentinel header
        WR_INIT_BLK,   // single free block at unit 1
        WR_UNLINK,     // exact fit: link[prev] = link[p]
        WR_SHRINK,     // split: size[p] -= units
        WR_TAIL,       // split: size[tail] = units
        WR_JOIN_UP,    // free: header of bp, joined with upper neighbor
        WR_JOIN_DN     // free: header of p, joined with bp
    } wr_sel_t;

    typedef enum logic [1:0] {
        P_HOLD,
        P_ROVER,
        P_LINK
    } p_sel_t;

    typedef enum logic [1:0] {
        PREV_HOLD,
        PREV_ROVER,
        PREV_P
    } prev_sel_t;

    typedef enum logic [2:0] {
        CAP_NONE,
        CAP_NX,        // nx <= link read data
        CAP_BP,        // size[bp], link[nx]
        CAP_NSZ,       // size[nx]
        CAP_PSZ        // size[p]
    } cap_sel_t;

    typedef enum logic [1:0] {
        ROV_HOLD,
        ROV_ZERO,
        ROV_PREV,
        ROV_P
    } rov_sel_t;

    typedef enum logic [2:0] {
        RES_HOLD,
        RES_CLEAR,
        RES_GRANT_P,
        RES_GRANT_TAIL,
        RES_FAIL
    } res_sel_t;

    typedef struct packed {
        logic       load;
        rd_sel_t    rd_sel;
        wr_sel_t    wr_sel;
        p_sel_t     p_sel;
        prev_sel_t  prev_sel;
        logic       cnt_clr;
        logic       cnt_inc;
        cap_sel_t   cap_sel;
        rov_sel_t   rov_sel;
        res_sel_t   res_sel;
    } ffa_ctl_t;

    typedef struct packed {
        logic fit;       // size[p] >= units
        logic exact;     // size[p] == units
        logic at_rover;  // p == rover
        logic cnt_end;   // walk step limit reached
        logic gap;       // bp belongs between p and link[p]
    } ffa_stat_t;

endpackage

[sv/ffa_ram.sv]
// ffa_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffa_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/ffa_dpath.sv]
// ffa_dpath: allocator datapath - link/size RAMs, walk registers, join/split arithmetic.
// Depends on ffa_pkg and ffa_ram; driven by ffa_ctrl through ffa_ctl_t.
module ffa_dpath
    import ffa_pkg::*;
#(
    parameter int HEAP_DEPTH = 4096,
    parameter int UNIT_BYTES = 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [HEAP_UNITS_W-1:0] cfg_wdata,
    input  ffa_req_t                request,
    input  ffa_ctl_t                ctl,
    output ffa_stat_t               stat,
    output ffa_rsp_t                result
);

    localparam int AW      = $clog2(HEAP_DEPTH);
    localparam int CW      = AW + 1;
    localparam int UB_SH   = $clog2(UNIT_BYTES);
    localparam int UNITS_W = REQ_BYTES_W - UB_SH + 1;
    localparam int CMP_W   = ((AW > UNITS_W) ? AW : UNITS_W) + 1;
    localparam int HCW     = ((AW > HEAP_UNITS_W) ? AW : HEAP_UNITS_W) + 1;
    localparam logic [AW-1:0] TOP_UNIT   = AW'(HEAP_DEPTH - 1);
    localparam logic [CW-1:0] WALK_LIMIT = CW'(HEAP_DEPTH);

    logic [HEAP_UNITS_W-1:0] heap_units_reg;
    logic [AW-1:0]           rover_reg;
    logic [AW-1:0]           p_reg, prev_reg, nx_reg, bp_reg, tail_reg;
    logic [UNITS_W-1:0]      units_reg;
    logic [CW-1:0]           cnt_reg;
    logic [AW-1:0]           sb_reg, lnx_reg, snx_reg, sp_reg, sbn_reg, lbn_reg;
    ffa_rsp_t                result_reg;

    logic [AW-1:0]           link_rd, size_rd;
    logic [AW-1:0]           link_ra, size_ra;
    logic                    link_we, size_we;
    logic [AW-1:0]           link_wa, size_wa, link_wd, size_wd;

    logic [REQ_BYTES_W:0]    bytes_up;
    logic [UNITS_W-1:0]      units_in;
    logic [AW-1:0]           shrink;
    logic [AW-1:0]           blk_units;
    logic                    up_join, dn_join;
    logic [AW-1:0]           sbn_next, lbn_next;

    // units = ceil(bytes / UNIT_BYTES) + 1 header unit, full width
    assign bytes_up = {1'b0, request.request_bytes} + (REQ_BYTES_W+1)'(UNIT_BYTES - 1);
    assign units_in = UNITS_W'(bytes_up >> UB_SH) + UNITS_W'(1);

    assign shrink    = size_rd - AW'(units_reg);
    assign blk_units = (HCW'(heap_units_reg) > HCW'(TOP_UNIT)) ? TOP_UNIT : AW'(heap_units_reg);

    // block ends compared at full width: a block reaching the top never meets the sentinel
    assign up_join  = (CW'(bp_reg) + CW'(sb_reg)) == CW'(nx_reg);
    assign dn_join  = (CW'(p_reg) + CW'(sp_reg)) == CW'(bp_reg);
    assign sbn_next = up_join ? (sb_reg + snx_reg) : sb_reg;
    assign lbn_next = up_join ? lnx_reg : nx_reg;

    always_comb
    begin
        stat.fit      = CMP_W'(size_rd) >= CMP_W'(units_reg);
        stat.exact    = CMP_W'(size_rd) == CMP_W'(units_reg);
        stat.at_rover = p_reg == rover_reg;
        stat.cnt_end  = cnt_reg == WALK_LIMIT;
        stat.gap      = ((bp_reg > p_reg) && (bp_reg < link_rd)) ||
                        ((p_reg >= link_rd) && ((bp_reg > p_reg) || (bp_reg < link_rd)));
    end

    // read address mux
    always_comb
    begin
        link_ra = p_reg;
        size_ra = p_reg;
        unique case (ctl.rd_sel)
            RD_NONE:    ;
            RD_ROVER:   begin link_ra = rover_reg; size_ra = rover_reg; end
            RD_LINK:    begin link_ra = link_rd;   size_ra = link_rd;   end
            RD_BP_NX:   begin link_ra = nx_reg;    size_ra = bp_reg;    end
            RD_NX_SIZE: size_ra = nx_reg;
            RD_P_SIZE:  size_ra = p_reg;
            default:    ;
        endcase
    end

    // write port mux
    always_comb
    begin
        link_we = 1'b0;
        size_we = 1'b0;
        link_wa = p_reg;
        size_wa = p_reg;
        link_wd = '0;
        size_wd = '0;
        unique case (ctl.wr_sel)
            WR_NONE: ;
            WR_INIT_SENT:
            begin
                link_we = 1'b1; link_wa = AW'(0); link_wd = AW'(1);
                size_we = 1'b1; size_wa = AW'(0); size_wd = AW'(0);
            end
            WR_INIT_BLK:
            begin
                link_we = 1'b1; link_wa = AW'(1); link_wd = AW'(0);
                size_we = 1'b1; size_wa = AW'(1); size_wd = blk_units;
            end
            WR_UNLINK:
            begin
                link_we = 1'b1; link_wa = prev_reg; link_wd = link_rd;
            end
            WR_SHRINK:
            begin
                size_we = 1'b1; size_wa = p_reg; size_wd = shrink;
            end
            WR_TAIL:
            begin
                size_we = 1'b1; size_wa = tail_reg; size_wd = AW'(units_reg);
            end
            WR_JOIN_UP:
            begin
                size_we = up_join; size_wa = bp_reg; size_wd = sbn_next;
                link_we = 1'b1;    link_wa = bp_reg; link_wd = lbn_next;
            end
            WR_JOIN_DN:
            begin
                size_we = dn_join; size_wa = p_reg; size_wd = sp_reg + sbn_reg;
                link_we = 1'b1;    link_wa = p_reg; link_wd = dn_join ? lbn_reg : bp_reg;
            end
            default: ;
        endcase
    end

    ffa_ram #(.WIDTH(AW), .DEPTH(HEAP_DEPTH)) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_wa),
        .wdata (link_wd),
        .raddr (link_ra),
        .rdata (link_rd)
    );

    ffa_ram #(.WIDTH(AW), .DEPTH(HEAP_DEPTH)) u_size_ram (
        .clk   (clk),
        .we    (size_we),
        .waddr (size_wa),
        .wdata (size_wd),
        .raddr (size_ra),
        .rdata (size_rd)
    );

    // control state: config register and roving pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_units_reg <= HEAP_UNITS_RESET;
            rover_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                heap_units_reg <= cfg_wdata;
            end
            unique case (ctl.rov_sel)
                ROV_HOLD: rover_reg <= rover_reg;
                ROV_ZERO: rover_reg <= '0;
                ROV_PREV: rover_reg <= prev_reg;
                ROV_P:    rover_reg <= p_reg;
            endcase
        end
    end

    // walk and payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            units_reg <= units_in;
            bp_reg    <= AW'(request.block_addr) - AW'(1);
        end

        unique case (ctl.p_sel)
            P_HOLD:  p_reg <= p_reg;
            P_ROVER: p_reg <= rover_reg;
            P_LINK:  p_reg <= link_rd;
            default: p_reg <= p_reg;
        endcase

        unique case (ctl.prev_sel)
            PREV_HOLD:  prev_reg <= prev_reg;
            PREV_ROVER: prev_reg <= rover_reg;
            PREV_P:     prev_reg <= p_reg;
            default:    prev_reg <= prev_reg;
        endcase

        priority if (ctl.cnt_clr)
        begin
            cnt_reg <= '0;
        end
        else if (ctl.cnt_inc)
        begin
            cnt_reg <= cnt_reg + CW'(1);
        end

        unique case (ctl.cap_sel)
            CAP_NONE: ;
            CAP_NX:   nx_reg <= link_rd;
            CAP_BP:
            begin
                sb_reg  <= size_rd;
                lnx_reg <= link_rd;
            end
            CAP_NSZ:  snx_reg <= size_rd;
            CAP_PSZ:  sp_reg  <= size_rd;
            default:  ;
        endcase

        if (ctl.wr_sel == WR_SHRINK)
        begin
            tail_reg <= p_reg + shrink;
        end
        if (ctl.wr_sel == WR_JOIN_UP)
        begin
            sbn_reg <= sbn_next;
            lbn_reg <= lbn_next;
        end

        unique case (ctl.res_sel)
            RES_HOLD:  result_reg <= result_reg;
            RES_CLEAR:
            begin
                result_reg.alloc_addr <= '0;
                result_reg.status     <= 1'b0;
            end
            RES_GRANT_P:
            begin
                result_reg.alloc_addr <= ADDR_FIELD_W'(p_reg + AW'(1));
                result_reg.status     <= 1'b0;
            end
            RES_GRANT_TAIL:
            begin
                result_reg.alloc_addr <= ADDR_FIELD_W'(tail_reg + AW'(1));
                result_reg.status     <= 1'b0;
            end
            RES_FAIL:
            begin
                result_reg.alloc_addr <= '0;
                result_reg.status     <= 1'b1;
            end
            default:   result_reg <= result_reg;
        endcase
    end

    assign result = result_reg;

endmodule

[sv/ffa_ctrl.sv]
// ffa_ctrl: allocator controller - sequences init, allocate and free over the datapath.
// Depends on ffa_pkg; issues ffa_ctl_t and reads ffa_stat_t.
module ffa_ctrl
    import ffa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  cmd_t      req_cmd,
    input  ffa_stat_t stat,
    output ffa_ctl_t  ctl,
    output logic      busy,
    output logic      done
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_NOP,
        S_INIT0,
        S_INIT1,
        S_A_HEAD,
        S_A_FIRST,
        S_A_SCAN,
        S_A_SPLIT,
        S_F_HEAD,
        S_F_SCAN,
        S_F_RD_BP,
        S_F_RD_NX,
        S_F_RD_P,
        S_F_JOIN_UP,
        S_F_JOIN_DN
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg;

    assign busy = state_reg != S_IDLE;
    assign done = done_reg;

    always_comb
    begin
        ctl.load     = 1'b0;
        ctl.rd_sel   = RD_NONE;
        ctl.wr_sel   = WR_NONE;
        ctl.p_sel    = P_HOLD;
        ctl.prev_sel = PREV_HOLD;
        ctl.cnt_clr  = 1'b0;
        ctl.cnt_inc  = 1'b0;
        ctl.cap_sel  = CAP_NONE;
        ctl.rov_sel  = ROV_HOLD;
        ctl.res_sel  = RES_HOLD;
        state_next   = state_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load = 1'b1;
                    unique case (req_cmd)
                        CMD_INIT:  state_next = S_INIT0;
                        CMD_ALLOC: state_next = S_A_HEAD;
                        CMD_FREE:  state_next = S_F_HEAD;
                        CMD_NOP:   state_next = S_NOP;
                    endcase
                end
            end
            S_NOP:
            begin
                ctl.res_sel = RES_CLEAR;
                state_next  = S_IDLE;
            end
            S_INIT0:
            begin
                ctl.wr_sel = WR_INIT_SENT;
                state_next = S_INIT1;
            end
            S_INIT1:
            begin
                ctl.wr_sel  = WR_INIT_BLK;
                ctl.rov_sel = ROV_ZERO;
                ctl.res_sel = RES_CLEAR;
                state_next  = S_IDLE;
            end
            S_A_HEAD:
            begin
                ctl.rd_sel   = RD_ROVER;
                ctl.prev_sel = PREV_ROVER;
                state_next   = S_A_FIRST;
            end
            S_A_FIRST:
            begin
                ctl.rd_sel  = RD_LINK;
                ctl.p_sel   = P_LINK;
                ctl.cnt_clr = 1'b1;
                state_next  = S_A_SCAN;
            end
            S_A_SCAN:
            begin
                priority if (stat.fit && stat.exact)
                begin
                    ctl.wr_sel  = WR_UNLINK;
                    ctl.rov_sel = ROV_PREV;
                    ctl.res_sel = RES_GRANT_P;
                    state_next  = S_IDLE;
                end
                else if (stat.fit)
                begin
                    ctl.wr_sel = WR_SHRINK;
                    state_next = S_A_SPLIT;
                end
                else if (stat.at_rover || stat.cnt_end)
                begin
                    ctl.res_sel = RES_FAIL;
                    state_next  = S_IDLE;
                end
                else
                begin
                    ctl.rd_sel   = RD_LINK;
                    ctl.p_sel    = P_LINK;
                    ctl.prev_sel = PREV_P;
                    ctl.cnt_inc  = 1'b1;
                end
            end
            S_A_SPLIT:
            begin
                ctl.wr_sel  = WR_TAIL;
                ctl.rov_sel = ROV_PREV;
                ctl.res_sel = RES_GRANT_TAIL;
                state_next  = S_IDLE;
            end
            S_F_HEAD:
            begin
                ctl.rd_sel  = RD_ROVER;
                ctl.p_sel   = P_ROVER;
                ctl.cnt_clr = 1'b1;
                state_next  = S_F_SCAN;
            end
            S_F_SCAN:
            begin
                priority if (stat.gap)
                begin
                    ctl.cap_sel = CAP_NX;
                    state_next  = S_F_RD_BP;
                end
                else if (stat.cnt_end)
                begin
                    // no place found: the free is dropped
                    ctl.res_sel = RES_CLEAR;
                    state_next  = S_IDLE;
                end
                else
                begin
                    ctl.rd_sel  = RD_LINK;
                    ctl.p_sel   = P_LINK;
                    ctl.cnt_inc = 1'b1;
                end
            end
            S_F_RD_BP:
            begin
                ctl.rd_sel = RD_BP_NX;
                state_next = S_F_RD_NX;
            end
            S_F_RD_NX:
            begin
                ctl.cap_sel = CAP_BP;
                ctl.rd_sel  = RD_NX_SIZE;
                state_next  = S_F_RD_P;
            end
            S_F_RD_P:
            begin
                ctl.cap_sel = CAP_NSZ;
                ctl.rd_sel  = RD_P_SIZE;
                state_next  = S_F_JOIN_UP;
            end
            S_F_JOIN_UP:
            begin
                ctl.cap_sel = CAP_PSZ;
                ctl.wr_sel  = WR_JOIN_UP;
                state_next  = S_F_JOIN_DN;
            end
            S_F_JOIN_DN:
            begin
                ctl.wr_sel  = WR_JOIN_DN;
                ctl.rov_sel = ROV_P;
                ctl.res_sel = RES_CLEAR;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= ctl.res_sel != RES_HOLD;
        end
    end

endmodule

[sv/first_fit_free_list_allocator.sv]
// first_fit_free_list_allocator: top level; joins ffa_ctrl and ffa_dpath, types from ffa_pkg.
// One word in flight; a new word is taken in the cycle done is high. The receiver cannot stall.
// Reset (rst_n low, async) clears the controller, rover to the sentinel, heap_units to 4095;
//   the link and size RAMs hold nothing defined until an init word.
module first_fit_free_list_allocator
    import ffa_pkg::*;
#(
    parameter int HEAP_DEPTH = 4096,  // heap units, power of two
    parameter int UNIT_BYTES = 8      // bytes per unit, power of two
) (
    input  logic                    clk,
    input  logic                    rst_n,
    // command channel
    input  logic                    start,
    output logic                    busy,
    input  ffa_req_t                request,
    // result channel
    output logic                    done,
    output ffa_rsp_t                result,
    // heap_units register
    input  logic                    cfg_we,
    input  logic [HEAP_UNITS_W-1:0] cfg_wdata
);

    ffa_ctl_t  ctl;
    ffa_stat_t stat;

    // Controller: one state per list step or RAM access; after the command dispatch all decisions come from stat.
    ffa_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .req_cmd (request.cmd),
        .stat    (stat),
        .ctl     (ctl),
        .busy    (busy),
        .done    (done)
    );

    // Datapath: headers live in two RAMs (link, size) read at the same unit during a walk,
    // so a header is examined each cycle. Free gathers the neighbor headers in three reads,
    // then writes the block header and after it the header of its lower neighbor.
    ffa_dpath #(
        .HEAP_DEPTH (HEAP_DEPTH),
        .UNIT_BYTES (UNIT_BYTES)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .request   (request),
        .ctl       (ctl),
        .stat      (stat),
        .result    (result)
    );

    // done is a single-cycle pulse and only shows while idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    // an accepted word always raises busy in the cycle after it is taken
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    // a failed allocate never reports an address
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status) |-> (result.alloc_addr == '0))
        else $error("no_space with nonzero address");

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// tb_top: self-checking bench for first_fit_free_list_allocator, with its own heap mirror class.
// Depends on ffa_pkg and the allocator RTL only.
module tb_top;
    import ffa_pkg::*;

    localparam int HEAP_SLOTS  = 4096;
    localparam int UNIT_SIZE   = 8;
    // Longest legal quiet spell is a corrupt-list walk of HEAP_SLOTS+1 headers plus a gap.
    localparam int STALL_LIMIT = 20000;
    localparam int PHASES      = 8;

    // Mirror of the heap: free-list headers, rover, heap_units and the queue of
    // result words still owed by the block.
    class heap_mirror;
        int unsigned link_mem [HEAP_SLOTS];
        int unsigned size_mem [HEAP_SLOTS];
        bit          size_known [HEAP_SLOTS];  // header size has been written since reset
        int unsigned rover;
        int unsigned heap_units;
        ffa_rsp_t    grant_queue [$];
        int          mismatch_count;

        function void power_up();
            int i;
            for (i = 0; i < HEAP_SLOTS; i++)
            begin
                size_known[i] = 1'b0;
            end
            rover          = 0;
            heap_units     = HEAP_UNITS_RESET;
            mismatch_count = 0;
            grant_queue.delete();
        endfunction

        // First fit from just past the rover; split keeps the head, hands out the tail.
        function bit carve_block(int unsigned units, output int unsigned payload);
            int unsigned prev;
            int unsigned p;
            int          n;
            prev    = rover;
            p       = link_mem[prev];
            payload = 0;
            for (n = 0; n <= HEAP_SLOTS; n++)
            begin
                if (size_mem[p] >= units)
                begin
                    if (size_mem[p] == units)
                    begin
                        link_mem[prev] = link_mem[p];
                    end
                    else
                    begin
                        size_mem[p]  -= units;
                        p             = (p + size_mem[p]) % HEAP_SLOTS;
                        size_mem[p]   = units;
                        size_known[p] = 1'b1;
                    end
                    rover   = prev;
                    payload = (p + 1) % HEAP_SLOTS;
                    return 1'b1;
                end
                if (p == rover)
                begin
                    return 1'b0;
                end
                prev = p;
                p    = link_mem[p];
            end
            return 1'b0;
        endfunction

        // Address-ordered insert with joins; ends compared at full width, sums wrap.
        function void insert_free(int unsigned bp);
            int unsigned p;
            int unsigned nx;
            int          n;
            bit          hit;
            p   = rover;
            n   = 0;
            hit = 1'b0;
            while (!hit && n <= HEAP_SLOTS)
            begin
                nx = link_mem[p];
                if ((bp > p && bp < nx) || (p >= nx && (bp > p || bp < nx)))
                begin
                    hit = 1'b1;
                end
                else
                begin
                    p = nx;
                    n++;
                end
            end
            if (!hit)
            begin
                return;
            end
            nx = link_mem[p];
            if (bp + size_mem[bp] == nx)
            begin
                size_mem[bp] = (size_mem[bp] + size_mem[nx]) % HEAP_SLOTS;
                link_mem[bp] = link_mem[nx];
            end
            else
            begin
                link_mem[bp] = nx;
            end
            if (p + size_mem[p] == bp)
            begin
                size_mem[p] = (size_mem[p] + size_mem[bp]) % HEAP_SLOTS;
                link_mem[p] = link_mem[bp];
            end
            else
            begin
                link_mem[p] = bp;
            end
            rover = p;
        endfunction

        // Called once per accepted word; queues and returns the result word it owes.
        function ffa_rsp_t apply_word(ffa_req_t word);
            ffa_rsp_t    grant;
            int unsigned units;
            int unsigned payload;
            int unsigned field;
            grant.alloc_addr = '0;
            grant.status     = 1'b0;
            case (word.cmd)
                CMD_INIT:
                begin
                    size_mem[0]   = 0;
                    link_mem[0]   = 1;
                    size_mem[1]   = heap_units;
                    link_mem[1]   = 0;
                    size_known[0] = 1'b1;
                    size_known[1] = 1'b1;
                    rover         = 0;
                end
                CMD_ALLOC:
                begin
                    field = word.request_bytes;
                    units = (field + UNIT_SIZE - 1) / UNIT_SIZE + 1;
                    if (carve_block(units, payload))
                    begin
                        grant.alloc_addr = payload[ADDR_FIELD_W-1:0];
                    end
                    else
                    begin
                        grant.status = 1'b1;
                    end
                end
                CMD_FREE:
                begin
                    field = word.block_addr;
                    insert_free((field + HEAP_SLOTS - 1) % HEAP_SLOTS);
                end
                default:
                begin
                end
            endcase
            grant_queue.push_back(grant);
            return grant;
        endfunction

        task flag_mismatch(string what, int unsigned got, int unsigned want);
            mismatch_count++;
            $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
        endtask

        task check_result(ffa_rsp_t got);
            ffa_rsp_t want;
            if (grant_queue.size() == 0)
            begin
                flag_mismatch("unrequested result word, alloc_addr", got.alloc_addr, 0);
                return;
            end
            want = grant_queue.pop_front();
            if (got.alloc_addr !== want.alloc_addr)
            begin
                flag_mismatch("alloc_addr", got.alloc_addr, want.alloc_addr);
            end
            if (got.status !== want.status)
            begin
                flag_mismatch("status", got.status, want.status);
            end
        endtask
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    ffa_req_t                request;
    logic                    done;
    ffa_rsp_t                result;
    logic                    cfg_we;
    logic [HEAP_UNITS_W-1:0] cfg_wdata;

    heap_mirror  mirror;
    int unsigned live_blocks [$];   // payloads handed out and not yet freed
    int unsigned freed_blocks [$];  // recent frees, for double-free stimulus
    int          taint_left;        // items until a re-init after a corrupting free
    bit          steady;            // sender never pauses while set
    int          stall_cycles;

    first_fit_free_list_allocator #(
        .HEAP_DEPTH (HEAP_SLOTS),
        .UNIT_BYTES (UNIT_SIZE)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Results cannot be held off: every done cycle carries one word to check.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            mirror.check_result(result);
        end
    end

    // Watchdog: any accepted command or result word restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Fields the command does not use carry random noise.
    function automatic ffa_req_t compose(cmd_t c, int unsigned bytes, int unsigned payload);
        logic [31:0] r;
        ffa_req_t    word;
        r                  = $urandom;
        word.cmd           = c;
        word.request_bytes = (c == CMD_ALLOC) ? bytes[REQ_BYTES_W-1:0] : r[15:0];
        word.block_addr    = (c == CMD_FREE) ? payload[ADDR_FIELD_W-1:0] : r[27:16];
        return word;
    endfunction

    task automatic pause_sender(input int cycles);
        logic [31:0] r;
        repeat (cycles)
        begin
            @(negedge clk);
            r       = $urandom;
            start   <= 1'b0;
            request <= compose(cmd_t'(r[1:0]), r[31:16], r[15:4]);
        end
    endtask

    // Offer one word and hold it until the block takes it. start stays high on
    // return so a back-to-back word needs no drop in between.
    task automatic send_word(input ffa_req_t word, output ffa_rsp_t grant);
        if (!steady && $urandom_range(0, 99) < 18)
        begin
            pause_sender($urandom_range(1, 10));
        end
        @(negedge clk);
        start   <= 1'b1;
        request <= word;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        grant = mirror.apply_word(word);
    endtask

    // Drop start, then wait for every owed word and an idle block.
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        @(posedge clk);
        while (mirror.grant_queue.size() != 0 || busy)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_heap_units(input int unsigned units);
        drain();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= units[HEAP_UNITS_W-1:0];
        @(negedge clk);
        cfg_we    <= 1'b0;
        mirror.heap_units = units;
    endtask

    task automatic fresh_heap();
        ffa_rsp_t grant;
        send_word(compose(CMD_INIT, 0, 0), grant);
        live_blocks.delete();
        freed_blocks.delete();
        taint_left = 0;
    endtask

    // Walk through the special cases on the reset-default heap of 4095 units.
    task automatic directed_words();
        ffa_rsp_t    grant;
        int unsigned a_top;
        int unsigned a_one;
        int unsigned a_eight;
        int unsigned a_nine;
        int unsigned a_sixteen;
        int unsigned a_whole;
        send_word(compose(CMD_NOP, 0, 0), grant);
        send_word(compose(CMD_INIT, 0, 0), grant);
        // zero bytes is one header unit: carved from the top slot, payload wraps to 0
        send_word(compose(CMD_ALLOC, 0, 0), grant);
        a_top = grant.alloc_addr;
        send_word(compose(CMD_ALLOC, 65535, 0), grant);  // larger than any heap
        send_word(compose(CMD_ALLOC, 1, 0), grant);
        a_one = grant.alloc_addr;
        send_word(compose(CMD_ALLOC, 8, 0), grant);
        a_eight = grant.alloc_addr;
        send_word(compose(CMD_ALLOC, 9, 0), grant);
        a_nine = grant.alloc_addr;
        send_word(compose(CMD_ALLOC, 16, 0), grant);
        a_sixteen = grant.alloc_addr;
        // plain insert, join below, join both sides, top block (no join with
        // the sentinel), then the last gap closes the heap into one block again
        send_word(compose(CMD_FREE, 0, a_eight), grant);
        send_word(compose(CMD_FREE, 0, a_sixteen), grant);
        send_word(compose(CMD_FREE, 0, a_nine), grant);
        send_word(compose(CMD_FREE, 0, a_top), grant);
        send_word(compose(CMD_FREE, 0, a_one), grant);
        // exact fit takes the whole 4095-unit block, then nothing is left
        send_word(compose(CMD_ALLOC, 4094 * UNIT_SIZE, 0), grant);
        a_whole = grant.alloc_addr;
        send_word(compose(CMD_ALLOC, 0, 0), grant);
        send_word(compose(CMD_FREE, 0, a_whole), grant);
        // double free: the header is already a list node, so the walk runs to
        // its step limit and the word is dropped
        send_word(compose(CMD_FREE, 0, a_whole), grant);
        fresh_heap();
    endtask

    task automatic random_word();
        ffa_rsp_t    grant;
        int unsigned roll;
        int unsigned size_roll;
        int unsigned pick;
        int unsigned slot;
        int unsigned bytes;
        roll = $urandom_range(0, 99);
        if (taint_left == 1 || roll < 2)
        begin
            fresh_heap();
            return;
        end
        if (taint_left > 0)
        begin
            taint_left--;
        end
        if (roll < 5)
        begin
            send_word(compose(CMD_NOP, 0, 0), grant);
            return;
        end
        // Broken frees: a stale payload or any address whose header holds a size.
        // Headers never written stay out of reach.
        if (roll < 7)
        begin
            if (roll == 5 && freed_blocks.size() > 0)
            begin
                pick = freed_blocks[$urandom_range(0, freed_blocks.size() - 1)];
            end
            else
            begin
                pick = $urandom_range(0, HEAP_SLOTS - 1);
            end
            if (mirror.size_known[(pick + HEAP_SLOTS - 1) % HEAP_SLOTS])
            begin
                send_word(compose(CMD_FREE, 0, pick), grant);
                if (taint_left == 0)
                begin
                    taint_left = 6;
                end
                return;
            end
        end
        if (roll < 50 && live_blocks.size() > 0)
        begin
            slot = $urandom_range(0, live_blocks.size() - 1);
            pick = live_blocks[slot];
            live_blocks.delete(slot);
            send_word(compose(CMD_FREE, 0, pick), grant);
            freed_blocks.push_back(pick);
            if (freed_blocks.size() > 16)
            begin
                void'(freed_blocks.pop_front());
            end
            return;
        end
        // mostly small requests so the list stays busy; a few that cannot fit
        size_roll = $urandom_range(0, 99);
        if (size_roll < 70)
        begin
            bytes = $urandom_range(0, 127);
        end
        else if (size_roll < 90)
        begin
            bytes = $urandom_range(128, 4095);
        end
        else if (size_roll < 97)
        begin
            bytes = $urandom_range(4096, 40000);
        end
        else
        begin
            bytes = $urandom_range(0, 65535);
        end
        send_word(compose(CMD_ALLOC, bytes, 0), grant);
        if (!grant.status)
        begin
            live_blocks.push_back(grant.alloc_addr);
        end
    endtask

    // Heap settings per phase: reset default first, then the extremes and a spread.
    // Phase 3 runs without any sender pauses.
    int unsigned phase_units [PHASES] = '{4095, 1, 0, 4095, 2, 37, 1000, 300};
    int          phase_words [PHASES] = '{150, 40, 25, 200, 40, 120, 120, 120};

    initial
    begin
        int ph;
        int k;
        mirror       = new();
        mirror.power_up();
        rst_n        = 1'b0;
        start        = 1'b0;
        request      = '0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        steady       = 1'b0;
        taint_left   = 0;
        phase_units[6] = $urandom_range(1, 4095);
        repeat (8)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        rst_n = 1'b1;

        for (ph = 0; ph < PHASES; ph++)
        begin
            steady = (ph == 3);
            if (ph == 0)
            begin
                directed_words();
            end
            else
            begin
                write_heap_units(phase_units[ph]);
                fresh_heap();
            end
            for (k = 0; k < phase_words[ph]; k++)
            begin
                random_word();
            end
        end

        drain();
        repeat (16)
        begin
            @(posedge clk);
        end
        if (mirror.mismatch_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[sim.f]
sv/ffa_pkg.sv
sv/ffa_ram.sv
sv/ffa_dpath.sv
sv/ffa_ctrl.sv
sv/first_fit_free_list_allocator.sv
test/tb_top.sv
